@@ src/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg: shared types and constants for the MIDI track event parser
// Phase codes, result kinds, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int VLQ_MAX_BYTES = 4;
	localparam int VCNT_W        = 3;
	localparam int TICK_W        = 32;
	localparam int VLQ_W         = 28;
	localparam int TEMPO_W       = 24;
	localparam int BPM_W         = 26;
	localparam int SLEN_W        = 29;
	localparam int DIV_STEPS     = BPM_W;
	localparam logic [BPM_W-1:0] USEC_PER_MIN = BPM_W'(60000000);

	localparam logic [2:0] K_CHAN  = 3'd0;
	localparam logic [2:0] K_SYSEX = 3'd1;
	localparam logic [2:0] K_TEMPO = 3'd2;
	localparam logic [2:0] K_EOT   = 3'd3;
	localparam logic [2:0] K_ERR   = 3'd4;

	localparam logic [7:0] META_EOT   = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] META_PORT  = 8'h21;
	localparam logic [7:0] ST_SYSEX   = 8'hF0;
	localparam logic [7:0] ST_ESC     = 8'hF7;
	localparam logic [7:0] ST_META    = 8'hFF;

	typedef enum logic [3:0] {
		PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SYSLEN, PH_SYSDATA,
		PH_METATYPE, PH_METALEN, PH_TEMPO, PH_SKIP, PH_HALT
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_DIV  = 5'b00100,
		S_OUT1 = 5'b01000,
		S_OUT2 = 5'b10000
	} ctl_state_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [TICK_W-1:0] abs_tick;
		logic [3:0]        msg_type;
		logic [3:0]        chan;
		logic [6:0]        first_data;
		logic [6:0]        second_data;
		logic [SLEN_W-1:0] sysex_len;
		logic [BPM_W-1:0]  bpm;
	} result_t;

	typedef struct packed {
		logic load;     // capture input byte
		logic decode;   // run one decode step, update parser state
		logic div_step; // one restoring divider step
		logic sel_second;
	} dp_cmd_t;

	typedef struct packed {
		logic n_res_valid;      // decode step produced results
		logic two_res;          // two results pending
		logic need_div;         // first result is a tempo, needs division
		logic div_done;
	} dp_sts_t;

endpackage

@@ src/mtep_datapath.sv @@
// ----------------------------------------------------------------------------
// mtep_datapath: parser state registers, decode logic, tempo divider
// One decode step per byte; the divider runs one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtep_datapath
	import mtep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  byte_in,
	input  logic        chunk_end,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output result_t     res,
	output logic        res_last
);

	phase_t              phase_q;
	logic [TICK_W-1:0]   tick_q;
	logic [7:0]          run_st_q, cur_st_q, meta_q, b_q;
	logic [VLQ_W-1:0]    vlq_q, left_q;
	logic [VCNT_W-1:0]   vcnt_q;
	logic [6:0]          held_q;
	logic [TEMPO_W-1:0]  tempo_q;
	logic                last_q;

	result_t r0_q, r1_q;
	logic    two_q, div_q, any_q;

	// divider
	logic [BPM_W-1:0]   quo_q, dvd_q;
	logic [TEMPO_W:0]   rem_q;
	logic [4:0]         dcnt_q;
	logic [TEMPO_W-1:0] div_tempo_q;

	// next-state decode
	phase_t              ph_n;
	logic [TICK_W-1:0]   tick_n;
	logic [7:0]          run_n, cur_n, meta_n;
	logic [VLQ_W-1:0]    vlq_n, left_n;
	logic [VCNT_W-1:0]   vcnt_n;
	logic [6:0]          held_n;
	logic [TEMPO_W-1:0]  tempo_n;
	logic [1:0]          n;
	result_t             e0, e1, rr;
	logic                need_div;
	logic [VLQ_W-1:0]    vtake;
	logic                vmore, vover;
	logic [VLQ_W-1:0]    left_dec;
	logic [7:0]          cmdb;

	always_comb begin
		ph_n = phase_q; tick_n = tick_q; run_n = run_st_q; cur_n = cur_st_q;
		meta_n = meta_q; vlq_n = vlq_q; left_n = left_q; vcnt_n = vcnt_q;
		held_n = held_q; tempo_n = tempo_q;
		n = 2'd0; need_div = 1'b0; e0 = '0; e1 = '0; rr = '0; cmdb = 8'h00;
		vtake = {vlq_q[VLQ_W-8:0], b_q[6:0]};
		vmore = b_q[7];
		vover = vmore && (32'(vcnt_q) + 32'd1 >= 32'(VLQ_MAX_BYTES));
		left_dec = left_q - VLQ_W'(1);
		case (phase_q)
			PH_DELTA, PH_SYSLEN, PH_METALEN: begin
				vlq_n = vtake;
				if (vover) begin
					rr.kind = K_ERR; n = 2'd1; ph_n = PH_HALT;
				end else if (vmore) begin
					vcnt_n = vcnt_q + VCNT_W'(1);
				end else if (phase_q == PH_DELTA) begin
					tick_n = tick_q + TICK_W'(vtake);
					ph_n = PH_STATUS;
				end else if (phase_q == PH_SYSLEN) begin
					left_n = vtake;
					if (vtake == '0) begin
						rr.kind = K_SYSEX; n = 2'd1;
						rr.sysex_len = SLEN_W'(vtake) + SLEN_W'(cur_st_q == ST_SYSEX);
						ph_n = PH_DELTA; vlq_n = '0; vcnt_n = '0;
					end else ph_n = PH_SYSDATA;
				end else begin
					left_n = vtake;
					if (meta_q == META_EOT) begin
						rr.kind = K_EOT; n = 2'd1; ph_n = PH_HALT;
					end else if (meta_q == META_TEMPO) begin
						if (vtake < VLQ_W'(3)) begin
							rr.kind = K_ERR; n = 2'd1; ph_n = PH_HALT;
						end else begin
							vcnt_n = '0; tempo_n = '0; ph_n = PH_TEMPO;
						end
					end else if (meta_q == META_PORT && vtake == '0) begin
						rr.kind = K_ERR; n = 2'd1; ph_n = PH_HALT;
					end else if (vtake == '0) begin
						ph_n = PH_DELTA; vlq_n = '0; vcnt_n = '0;
					end else ph_n = PH_SKIP;
				end
			end
			PH_STATUS, PH_DATA1: begin
				if (phase_q == PH_STATUS && !b_q[7] && run_st_q == 8'h00) begin
					rr.kind = K_ERR; n = 2'd1; ph_n = PH_HALT;
				end else begin
					if (phase_q == PH_DATA1) cmdb = cur_st_q;
					else cmdb = b_q[7] ? b_q : run_st_q;
					if (phase_q == PH_STATUS && b_q[7] && b_q < 8'hF0) run_n = b_q;
					cur_n = cmdb;
					if (cmdb < 8'hF0) begin
						if (phase_q == PH_STATUS && b_q[7]) ph_n = PH_DATA1;
						else if (cmdb[7:4] != 4'hC && cmdb[7:4] != 4'hD) begin
							held_n = b_q[6:0]; ph_n = PH_DATA2;
						end else begin
							rr.kind = K_CHAN; rr.msg_type = cmdb[7:4];
							rr.chan = cmdb[3:0]; rr.first_data = b_q[6:0];
							n = 2'd1; ph_n = PH_DELTA; vlq_n = '0; vcnt_n = '0;
						end
					end else if (cmdb == ST_SYSEX || cmdb == ST_ESC) begin
						ph_n = PH_SYSLEN; vlq_n = '0; vcnt_n = '0;
					end else if (cmdb == ST_META) ph_n = PH_METATYPE;
					else begin
						rr.kind = K_ERR; n = 2'd1; ph_n = PH_HALT;
					end
				end
			end
			PH_DATA2: begin
				rr.kind = K_CHAN; rr.msg_type = cur_st_q[7:4]; rr.chan = cur_st_q[3:0];
				rr.first_data = held_q; rr.second_data = b_q[6:0];
				n = 2'd1; ph_n = PH_DELTA; vlq_n = '0; vcnt_n = '0;
			end
			PH_SYSDATA: begin
				left_n = left_dec;
				if (left_dec == '0) begin
					rr.kind = K_SYSEX; n = 2'd1;
					rr.sysex_len = SLEN_W'(vlq_q) + SLEN_W'(cur_st_q == ST_SYSEX);
					ph_n = PH_DELTA; vlq_n = '0; vcnt_n = '0;
				end
			end
			PH_METATYPE: begin
				meta_n = b_q; ph_n = PH_METALEN; vlq_n = '0; vcnt_n = '0;
			end
			PH_TEMPO: begin
				tempo_n = {tempo_q[TEMPO_W-9:0], b_q};
				left_n = left_dec;
				vcnt_n = vcnt_q + VCNT_W'(1);
				if (vcnt_n >= VCNT_W'(3)) begin
					if (tempo_n == '0) begin
						rr.kind = K_ERR; n = 2'd1; ph_n = PH_HALT;
					end else begin
						rr.kind = K_TEMPO; n = 2'd1; need_div = 1'b1;
						if (left_dec == '0) begin
							ph_n = PH_DELTA; vlq_n = '0; vcnt_n = '0;
						end else ph_n = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				left_n = left_dec;
				if (left_dec == '0) begin
					ph_n = PH_DELTA; vlq_n = '0; vcnt_n = '0;
				end
			end
			default: ph_n = PH_HALT;
		endcase
		rr.abs_tick = tick_n;
		e0 = rr;
		e1 = '0; e1.kind = K_ERR; e1.abs_tick = tick_n;
		if (last_q && ph_n != PH_HALT) begin
			if (n == 2'd0) begin
				e0 = e1; n = 2'd1;
			end else n = 2'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA; tick_q <= '0; run_st_q <= '0; cur_st_q <= '0;
			vlq_q <= '0; vcnt_q <= '0; held_q <= '0; meta_q <= '0;
			left_q <= '0; tempo_q <= '0; two_q <= 1'b0; div_q <= 1'b0;
			any_q <= 1'b0; dcnt_q <= '0;
		end else if (cmd.decode) begin
			any_q <= n != 2'd0;
			two_q <= n == 2'd2;
			div_q <= need_div;
			dcnt_q <= '0;
			if (last_q) begin
				phase_q <= PH_DELTA; tick_q <= '0; run_st_q <= '0; cur_st_q <= '0;
				vlq_q <= '0; vcnt_q <= '0; held_q <= '0; meta_q <= '0;
				left_q <= '0; tempo_q <= '0;
			end else begin
				phase_q <= ph_n; tick_q <= tick_n; run_st_q <= run_n; cur_st_q <= cur_n;
				vlq_q <= vlq_n; vcnt_q <= vcnt_n; held_q <= held_n; meta_q <= meta_n;
				left_q <= left_n; tempo_q <= tempo_n;
			end
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 5'd1;
		end
	end

	// payload and divider registers
	logic [TEMPO_W:0] rem_sh;
	always_comb rem_sh = {rem_q[TEMPO_W-1:0], dvd_q[BPM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_q <= byte_in; last_q <= chunk_end;
		end
		if (cmd.decode) begin
			r0_q <= e0; r1_q <= e1;
			dvd_q <= USEC_PER_MIN; rem_q <= '0; quo_q <= '0;
			// divisor held in tempo_n (captured in tempo_q unless chunk end)
			div_tempo_q <= tempo_n;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[BPM_W-2:0], 1'b0};
			if (rem_sh >= {1'b0, div_tempo_q}) begin
				rem_q <= rem_sh - {1'b0, div_tempo_q};
				quo_q <= {quo_q[BPM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[BPM_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		res = cmd.sel_second ? r1_q : r0_q;
		if (!cmd.sel_second && div_q) res.bpm = quo_q;
		res_last = cmd.sel_second || !two_q;
		sts.n_res_valid = any_q;
		sts.two_res = two_q;
		sts.need_div = div_q;
		sts.div_done = dcnt_q == 5'(DIV_STEPS);
	end

endmodule

@@ src/mtep_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtep_ctrl: sequencing controller
// Accepts a byte, runs a decode step, runs the divider for tempo events,
// then presents up to two results.
// ----------------------------------------------------------------------------
module mtep_ctrl
	import mtep_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctl_state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) state_n = S_DEC;
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				state_n = S_DIV;
			end
			S_DIV: begin
				if (!sts.n_res_valid) state_n = S_IDLE;
				else if (sts.need_div && !sts.div_done) cmd.div_step = 1'b1;
				else state_n = S_OUT1;
			end
			S_OUT1: begin
				out_valid = 1'b1;
				if (out_ready) state_n = sts.two_res ? S_OUT2 : S_IDLE;
			end
			S_OUT2: begin
				out_valid = 1'b1;
				cmd.sel_second = 1'b1;
				if (out_ready) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

`ifndef ASSERT_OFF
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_dec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.decode) else $error("decode did not follow load");
`endif

endmodule

@@ src/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser: byte-serial standard MIDI file track parser
// Decodes delta times, running status, channel/sysex/meta events and errors.
// ----------------------------------------------------------------------------
// A byte is accepted in S_IDLE, decoded in S_DEC, and its results are shown
//   from S_OUT1 and S_OUT2 after S_DIV; a new byte is taken only back in S_IDLE.
//   A tempo event also runs the bit-serial 60000000/tempo divider in S_DIV.
// Reset (arst_n low) clears the controller and the parser's state registers at once;
//   the chunk-end byte also returns the parser to its reset state.
module midi_track_event_parser
	import mtep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in
	input  logic        s_tlast,   // chunk_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [119:0] m_tdata,  // abs_tick, msg_type, chan, first_data,
	                               // second_data, sysex_len, bpm, zero pad
	output logic [2:0]  m_tuser,   // kind
	output logic        m_tlast    // last_of_run
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	result_t res;
	logic    res_last;

	// controller: handshake and sequencing
	mtep_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.sts, .cmd
	);

	// datapath: state, decode and tempo divider
	mtep_datapath u_dp (
		.clk, .arst_n,
		.byte_in(s_tdata), .chunk_end(s_tlast),
		.cmd, .sts, .res, .res_last
	);

	assign m_tuser = res.kind;
	assign m_tlast = res_last;
	// 32+4+4+7+7+29+26 = 109 bits, padded to 120
	assign m_tdata = {11'd0, res.bpm, res.sysex_len, res.second_data,
		res.first_data, res.chan, res.msg_type, res.abs_tick};

endmodule
